// File: hw/rtl/iapl_pkg.sv
// Shared types, constants and helper functions for the address literal parser.
// No dependencies; imported by iapl_parse, ip_address_literal_parser and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package iapl_pkg;

   localparam int WORDS       = 8;   // 16-bit words in an IPv6 address
   localparam int QUAD_WORDS  = 2;   // words taken by an embedded dotted quad
   localparam int QUAD_OCTETS = 4;
   localparam int OCTET_MAX   = 255;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_LEAD   = 3'd1,
      PH_GROUP  = 3'd2,
      PH_COLON  = 3'd3,
      PH_DCOLON = 3'd4,
      PH_QUAD   = 3'd5
   } phase_type;

   typedef logic [0:WORDS-1][15:0] word_vec_type;

   // head is left-aligned and written by index; tail shifts in from the low end
   typedef struct packed {
      word_vec_type             head;
      logic [16*WORDS-1:0]      tail;
      logic [3:0]               head_wc;
      logic [3:0]               tail_wc;
   } store_type;

   typedef struct packed {
      logic [0:QUAD_OCTETS-1][7:0] bytes;
      logic [2:0]                  index;
      logic [7:0]                  value;
      logic [1:0]                  digits;
      logic                        alive;
   } quad_type;

   localparam quad_type QUAD_RESET = '{bytes: '0, index: '0, value: '0, digits: '0,
                                       alive: 1'b1};

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic        parse_ok;
      logic        is_ipv6;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
   } result_type;

   function automatic hex_type hex_of(logic [7:0] c);
      hex_type r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.ok  = 1'b1;
         r.val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.ok  = 1'b1;
         r.val = c[3:0] + 4'd9;
      end
      return r;
   endfunction

   function automatic logic [3:0] store_level(store_type s, logic compress);
      return compress ? s.tail_wc : s.head_wc;
   endfunction

   function automatic store_type store_put(store_type s, logic compress, logic [15:0] w);
      store_type r;
      r = s;
      if (compress) begin
         r.tail    = {s.tail[16*WORDS-17:0], w};
         r.tail_wc = s.tail_wc + 4'd1;
      end else begin
         r.head[s.head_wc[2:0]] = w;
         r.head_wc              = s.head_wc + 4'd1;
      end
      return r;
   endfunction

   function automatic quad_type quad_digit(quad_type q, logic [3:0] d);
      quad_type   r;
      logic [11:0] v;
      r = q;
      v = 12'(q.value) * 12'd10 + 12'(d);
      if (q.alive) begin
         if (q.digits == 2'd3 || (q.digits == 2'd1 && q.value == 8'd0)) begin
            r.alive = 1'b0;
         end else if (v > 12'(OCTET_MAX)) begin
            r.alive = 1'b0;
         end else begin
            r.value  = v[7:0];
            r.digits = q.digits + 2'd1;
         end
      end
      return r;
   endfunction

   function automatic logic quad_can_close(quad_type q);
      return (q.digits != 2'd0) && (q.index < 3'(QUAD_OCTETS));
   endfunction

   function automatic quad_type quad_close(quad_type q);
      quad_type r;
      r                     = q;
      r.bytes[q.index[1:0]] = q.value;
      r.index               = q.index + 3'd1;
      r.value               = '0;
      r.digits              = '0;
      return r;
   endfunction

   function automatic quad_type quad_dot(quad_type q);
      quad_type r;
      r = q;
      if (q.alive) begin
         if (!quad_can_close(q)) begin
            r.alive = 1'b0;
         end else begin
            r = quad_close(q);
            if (r.index == 3'(QUAD_OCTETS)) begin
               r.alive = 1'b0;
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/iapl_parse.sv
// Parser state registers and per-character update; forms the result on the end byte.
// Depends on iapl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iapl_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_valid,
   input  logic [7:0]             step_char,
   output logic                   result_valid,
   output iapl_pkg::result_type   lit_result
);
   import iapl_pkg::*;

   store_type   store_ff,        store_in;
   logic        compress_ff,     compress_in;
   logic [15:0] group_value_ff,  group_value_in;
   logic [2:0]  group_digits_ff, group_digits_in;
   phase_type   phase_ff,        phase_in;
   quad_type    quad_ff,         quad_in;
   logic        colon_ff,        colon_in;
   logic        failed_ff,       failed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff        <= '0;
         compress_ff     <= 1'b0;
         group_value_ff  <= '0;
         group_digits_ff <= '0;
         phase_ff        <= PH_START;
         quad_ff         <= QUAD_RESET;
         colon_ff        <= 1'b0;
         failed_ff       <= 1'b0;
      end else if (step_valid) begin
         store_ff        <= store_in;
         compress_ff     <= compress_in;
         group_value_ff  <= group_value_in;
         group_digits_ff <= group_digits_in;
         phase_ff        <= phase_in;
         quad_ff         <= quad_in;
         colon_ff        <= colon_in;
         failed_ff       <= failed_in;
      end
   end

   always_comb begin
      hex_type   hx;
      logic      is_digit;
      logic      is_dot;
      logic      is_colon;
      logic      do_group;
      logic      do_compress;
      logic      fin;
      logic      v4;
      logic      v6;
      logic      ok;
      store_type st;
      quad_type  qc;

      store_in        = store_ff;
      compress_in     = compress_ff;
      group_value_in  = group_value_ff;
      group_digits_in = group_digits_ff;
      phase_in        = phase_ff;
      quad_in         = quad_ff;
      colon_in        = colon_ff;
      failed_in       = failed_ff;
      lit_result      = '0;
      result_valid    = step_valid && (step_char == CHAR_END);

      hx          = hex_of(step_char);
      is_digit    = (step_char >= 8'h30) && (step_char <= 8'h39);
      is_dot      = (step_char == CHAR_DOT);
      is_colon    = (step_char == CHAR_COLON);
      do_group    = 1'b0;
      do_compress = 1'b0;
      fin         = failed_ff;
      v4          = 1'b0;
      v6          = 1'b0;
      ok          = 1'b0;
      st          = store_ff;
      qc          = quad_ff;

      if (step_char != CHAR_END) begin
         if (!failed_ff) begin
            unique case (phase_ff)
               PH_START: begin
                  if (is_colon)   phase_in  = PH_LEAD;
                  else if (hx.ok) do_group  = 1'b1;
                  else            failed_in = 1'b1;
               end
               PH_LEAD: begin
                  if (is_colon) do_compress = 1'b1;
                  else          failed_in   = 1'b1;
               end
               PH_GROUP: do_group = 1'b1;
               PH_COLON: begin
                  if (is_colon)   do_compress = 1'b1;
                  else if (hx.ok) do_group    = 1'b1;
                  else            failed_in   = 1'b1;
               end
               PH_DCOLON: begin
                  if (hx.ok) do_group  = 1'b1;
                  else       failed_in = 1'b1;
               end
               PH_QUAD: begin
                  if (is_digit)    quad_in       = quad_digit(quad_ff, step_char[3:0]);
                  else if (is_dot) quad_in       = quad_dot(quad_ff);
                  else             quad_in.alive = 1'b0;
                  if (!quad_in.alive) failed_in = 1'b1;
               end
               default: failed_in = 1'b1;
            endcase

            if (do_compress) begin
               if (compress_ff) begin
                  failed_in = 1'b1;
               end else begin
                  compress_in     = 1'b1;
                  colon_in        = 1'b1;
                  group_value_in  = '0;
                  group_digits_in = '0;
                  quad_in         = QUAD_RESET;
                  phase_in        = PH_DCOLON;
               end
            end

            if (do_group) begin
               if (hx.ok) begin
                  if (group_digits_ff >= 3'd4) begin
                     failed_in = 1'b1;
                  end else begin
                     group_digits_in = group_digits_ff + 3'd1;
                     group_value_in  = {group_value_ff[11:0], hx.val};
                     if (is_digit) quad_in       = quad_digit(quad_ff, step_char[3:0]);
                     else          quad_in.alive = 1'b0;
                     phase_in = PH_GROUP;
                  end
               end else if (is_dot && phase_ff == PH_GROUP) begin
                  if (store_level(store_ff, compress_ff) > 4'(WORDS - QUAD_WORDS)) begin
                     failed_in = 1'b1;
                  end else begin
                     quad_in  = quad_dot(quad_ff);
                     phase_in = PH_QUAD;
                     if (!quad_in.alive) failed_in = 1'b1;
                  end
               end else if (is_colon && phase_ff == PH_GROUP) begin
                  if (store_level(store_ff, compress_ff) == 4'(WORDS)) begin
                     failed_in = 1'b1;
                  end else begin
                     store_in = store_put(store_ff, compress_ff, group_value_ff);
                  end
                  group_value_in  = '0;
                  group_digits_in = '0;
                  quad_in         = QUAD_RESET;
                  colon_in        = 1'b1;
                  phase_in        = PH_COLON;
               end else begin
                  failed_in = 1'b1;
               end
            end
         end
      end else begin
         // end of literal: close the open group or quad, then build the result
         if (!fin) begin
            unique case (phase_ff)
               PH_DCOLON: v6 = 1'b1;
               PH_GROUP: begin
                  if (store_level(st, compress_ff) == 4'(WORDS)) fin = 1'b1;
                  else st = store_put(st, compress_ff, group_value_ff);
                  v6 = 1'b1;
               end
               PH_QUAD: begin
                  if (!qc.alive || !quad_can_close(qc)) begin
                     fin = 1'b1;
                  end else begin
                     qc = quad_close(qc);
                     if (qc.index != 3'(QUAD_OCTETS)) begin
                        fin = 1'b1;
                     end else if (!colon_ff) begin
                        v4 = 1'b1;
                     end else if (store_level(st, compress_ff) > 4'(WORDS - QUAD_WORDS)) begin
                        fin = 1'b1;
                     end else begin
                        st = store_put(st, compress_ff, qc.bytes[0:1]);
                        st = store_put(st, compress_ff, qc.bytes[2:3]);
                        v6 = 1'b1;
                     end
                  end
               end
               default: fin = 1'b1;
            endcase
         end

         if (!fin && v4) begin
            lit_result.parse_ok   = 1'b1;
            lit_result.addr_lower = {32'd0, qc.bytes};
         end else if (!fin && v6) begin
            if (compress_ff) ok = (5'(st.head_wc) + 5'(st.tail_wc)) <= 5'(WORDS - 1);
            else             ok = (st.head_wc == 4'(WORDS));
            if (ok) begin
               lit_result.parse_ok = 1'b1;
               lit_result.is_ipv6  = 1'b1;
               {lit_result.addr_upper, lit_result.addr_lower} = st.head | st.tail;
            end
         end

         store_in        = '0;
         compress_in     = 1'b0;
         group_value_in  = '0;
         group_digits_in = '0;
         phase_in        = PH_START;
         quad_in         = QUAD_RESET;
         colon_in        = 1'b0;
         failed_in       = 1'b0;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ip_address_literal_parser.sv
// Address literal parser top level: input register, parser core, result register.
// Depends on iapl_pkg and iapl_parse.
//
// Usage:
//   req_ channel carries one character per transfer (req_char_code); a zero
//   byte ends the literal. Only the zero byte produces a transfer on the rsp_
//   channel: rsp_parse_ok, rsp_is_ipv6, rsp_addr_upper and rsp_addr_lower.
//   Failed literals report all-zero fields. After an error the rest of the
//   literal up to the zero byte is consumed silently.
// Path: a zero byte accepted into the input register is parsed from there and
//   its result is captured in the result register, which drives rsp_.
// Throughput: one character per cycle unless a zero byte waits on a full result
//   register, set by the combinational parser update between the two registers.
// Stall: while rsp_ready is low and a result is held, non-zero characters
//   keep flowing; a zero byte waits in the input register until the result
//   register frees, and req_ready drops behind it.
// Reset: synchronous, clears both valid flags and all parser state; the first
//   character after reset starts a new literal.
`timescale 1ns / 1ps
`default_nettype none

module ip_address_literal_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_parse_ok,
   output logic        rsp_is_ipv6,
   output logic [63:0] rsp_addr_upper,
   output logic [63:0] rsp_addr_lower
);
   import iapl_pkg::*;

   logic       in_valid_ff,  in_valid_in;
   logic [7:0] in_char_ff,   in_char_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff,       rsp_in;

   logic       out_free;
   logic       step_go;
   logic       res_valid;
   result_type res;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_go   = in_valid_ff && ((in_char_ff != CHAR_END) || out_free);
   assign req_ready = !in_valid_ff || step_go;

   iapl_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (step_go),
      .step_char    (in_char_ff),
      .result_valid (res_valid),
      .lit_result   (res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_char_code;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_char_ff <= in_char_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_parse_ok   = rsp_ff.parse_ok;
   assign rsp_is_ipv6    = rsp_ff.is_ipv6;
   assign rsp_addr_upper = rsp_ff.addr_upper;
   assign rsp_addr_lower = rsp_ff.addr_lower;

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_parse_ok |->
         !rsp_is_ipv6 && rsp_addr_upper == 64'd0 && rsp_addr_lower == 64'd0)
      else $error("failed literal with nonzero result fields");

   a_v4_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_ok && !rsp_is_ipv6 |->
         rsp_addr_upper == 64'd0 && rsp_addr_lower[63:32] == 32'd0)
      else $error("IPv4 result outside low 32 bits");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("channels not idle after reset");

   a_end_held : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_char_ff == CHAR_END && !out_free |=>
         in_valid_ff && in_char_ff == CHAR_END && rsp_valid_ff)
      else $error("end byte dropped while result register full");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for ip_address_literal_parser: random and directed address literals,
// checked against an in-bench parser model with valid/ready idling on both channels.
// Depends on iapl_pkg and the ip_address_literal_parser RTL.
`timescale 1ns / 1ps

module tb_top;
   import iapl_pkg::*;

   typedef struct {
      logic [7:0] ch;
      bit         hold;   // wait for all outstanding results before sending
   } char_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_parse_ok;
   logic        rsp_is_ipv6;
   logic [63:0] rsp_addr_upper;
   logic [63:0] rsp_addr_lower;

   char_item_type char_backlog[$];
   result_type  addr_expect[$];
   logic        req_fire = 1'b0;
   int          cyc = 0;
   int          errors = 0;
   int          chars_queued = 0;
   int          chars_sent = 0;
   int          v4_seen = 0, v6_seen = 0, rejected_seen = 0;
   bit          calm;

   // parser model state
   logic [7:0]  front_bytes[16];
   logic [7:0]  back_bytes[16];
   int          front_len, back_len;
   bit          squeezed;
   logic [15:0] grp_val;
   int          grp_digs;
   phase_type   phase;
   logic [7:0]  oct_bytes[4];
   int          oct_idx, oct_val, oct_digs;
   bit          oct_live;
   bit          any_colon;
   bit          broken;

   ip_address_literal_parser dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_parse_ok  (rsp_parse_ok),
      .rsp_is_ipv6   (rsp_is_ipv6),
      .rsp_addr_upper(rsp_addr_upper),
      .rsp_addr_lower(rsp_addr_lower)
   );

   always #1 clock = ~clock;

   assign calm = (cyc >= 500) && (cyc < 1300);

   function automatic int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   task octet_restart();
      for (int i = 0; i < 4; i++) oct_bytes[i] = 8'h00;
      oct_idx  = 0;
      oct_val  = 0;
      oct_digs = 0;
      oct_live = 1'b1;
   endtask

   task clear_literal();
      for (int i = 0; i < 16; i++) begin
         front_bytes[i] = 8'h00;
         back_bytes[i]  = 8'h00;
      end
      front_len = 0;
      back_len  = 0;
      squeezed  = 1'b0;
      grp_val   = 16'h0000;
      grp_digs  = 0;
      phase     = PH_START;
      octet_restart();
      any_colon = 1'b0;
      broken    = 1'b0;
   endtask

   task octet_digit(int d);
      int v;
      if (!oct_live) return;
      if (oct_digs >= 3 || (oct_digs == 1 && oct_val == 0)) begin
         oct_live = 1'b0;
         return;
      end
      v = oct_val * 10 + d;
      if (v > 255) begin
         oct_live = 1'b0;
         return;
      end
      oct_val = v;
      oct_digs++;
   endtask

   function bit octet_close();
      if (oct_digs == 0 || oct_idx > 3) begin
         oct_live = 1'b0;
         return 1'b0;
      end
      oct_bytes[oct_idx] = oct_val[7:0];
      oct_idx++;
      oct_val  = 0;
      oct_digs = 0;
      return 1'b1;
   endfunction

   task octet_dot();
      if (!oct_live) return;
      if (octet_close() && oct_idx == 4) oct_live = 1'b0;
   endtask

   function int fill_level();
      return squeezed ? back_len : front_len;
   endfunction

   task store_group();
      if (fill_level() + 2 > 16) begin
         broken = 1'b1;
         return;
      end
      if (squeezed) begin
         back_bytes[back_len]     = grp_val[15:8];
         back_bytes[back_len + 1] = grp_val[7:0];
         back_len += 2;
      end else begin
         front_bytes[front_len]     = grp_val[15:8];
         front_bytes[front_len + 1] = grp_val[7:0];
         front_len += 2;
      end
   endtask

   task group_char(logic [7:0] c);
      int h;
      h = hex_val(c);
      if (h >= 0) begin
         if (grp_digs >= 4) begin
            broken = 1'b1;
            return;
         end
         grp_digs++;
         grp_val = {grp_val[11:0], 4'(h)};
         if (c >= "0" && c <= "9") octet_digit(c - "0");
         else oct_live = 1'b0;
         phase = PH_GROUP;
      end else if (c == CHAR_DOT && phase == PH_GROUP) begin
         if (fill_level() + 4 > 16) begin
            broken = 1'b1;
            return;
         end
         octet_dot();
         phase = PH_QUAD;
         if (!oct_live) broken = 1'b1;
      end else if (c == CHAR_COLON && phase == PH_GROUP) begin
         store_group();
         grp_val   = 16'h0000;
         grp_digs  = 0;
         octet_restart();
         any_colon = 1'b1;
         phase     = PH_COLON;
      end else begin
         broken = 1'b1;
      end
   endtask

   task enter_squeeze();
      if (squeezed) begin
         broken = 1'b1;
         return;
      end
      squeezed  = 1'b1;
      any_colon = 1'b1;
      grp_val   = 16'h0000;
      grp_digs  = 0;
      octet_restart();
      phase     = PH_DCOLON;
   endtask

   // Advances the parser model by one character; the end byte queues the expected result.
   task take_char(logic [7:0] c);
      bit          ok, v6, v4;
      logic [7:0]  a[16];
      logic [63:0] up, lo;
      result_type  r;
      if (c != CHAR_END) begin
         if (broken) return;
         case (phase)
            PH_START: begin
               if (c == CHAR_COLON) phase = PH_LEAD;
               else if (hex_val(c) >= 0) group_char(c);
               else broken = 1'b1;
            end
            PH_LEAD: begin
               if (c == CHAR_COLON) enter_squeeze();
               else broken = 1'b1;
            end
            PH_GROUP: group_char(c);
            PH_COLON: begin
               if (c == CHAR_COLON) enter_squeeze();
               else if (hex_val(c) >= 0) group_char(c);
               else broken = 1'b1;
            end
            PH_DCOLON: begin
               if (hex_val(c) >= 0) group_char(c);
               else broken = 1'b1;
            end
            PH_QUAD: begin
               if (c >= "0" && c <= "9") octet_digit(c - "0");
               else if (c == CHAR_DOT) octet_dot();
               else oct_live = 1'b0;
               if (!oct_live) broken = 1'b1;
            end
            default: broken = 1'b1;
         endcase
         return;
      end
      ok = 1'b0;
      v6 = 1'b0;
      v4 = 1'b0;
      up = '0;
      lo = '0;
      if (!broken) begin
         if (phase == PH_DCOLON) begin
            v6 = 1'b1;
         end else if (phase == PH_GROUP) begin
            store_group();
            v6 = 1'b1;
         end else if (phase == PH_QUAD) begin
            if (!oct_live) broken = 1'b1;
            else if (!octet_close()) broken = 1'b1;
            else if (oct_idx != 4) broken = 1'b1;
            else if (!any_colon) v4 = 1'b1;
            else if (fill_level() + 4 > 16) broken = 1'b1;
            else begin
               for (int i = 0; i < 4; i++) begin
                  if (squeezed) back_bytes[back_len + i] = oct_bytes[i];
                  else front_bytes[front_len + i] = oct_bytes[i];
               end
               if (squeezed) back_len += 4;
               else front_len += 4;
               v6 = 1'b1;
            end
         end else begin
            broken = 1'b1;
         end
      end
      if (!broken && v4) begin
         ok = 1'b1;
         lo = {32'h0, oct_bytes[0], oct_bytes[1], oct_bytes[2], oct_bytes[3]};
      end else if (!broken && v6) begin
         ok = squeezed ? (front_len + back_len <= 14) : (front_len == 16);
         if (ok) begin
            for (int i = 0; i < 16; i++) a[i] = 8'h00;
            for (int i = 0; i < front_len; i++) a[i] = front_bytes[i];
            for (int i = 0; i < back_len; i++) a[16 - back_len + i] = back_bytes[i];
            for (int i = 0; i < 8; i++) begin
               up = {up[55:0], a[i]};
               lo = {lo[55:0], a[i + 8]};
            end
         end
      end
      r.parse_ok   = ok;
      r.is_ipv6    = ok && v6;
      r.addr_upper = ok ? up : 64'h0;
      r.addr_lower = ok ? lo : 64'h0;
      addr_expect.push_back(r);
      clear_literal();
   endtask

   // ---- literal generators ----

   function automatic string hex_group();
      string      s;
      int         n;
      logic [15:0] v;
      logic [3:0] nib;
      n = $urandom_range(1, 4);
      case ($urandom_range(7))
         0: v = 16'hffff;
         1: v = 16'h0000;
         default: v = 16'($urandom);
      endcase
      s = "";
      for (int k = n - 1; k >= 0; k--) begin
         nib = v[4*k +: 4];
         if (nib < 10) s = {s, $sformatf("%0d", nib)};
         else if ($urandom_range(1)) s = {s, $sformatf("%c", 8'h41 + nib - 10)};
         else s = {s, $sformatf("%c", 8'h61 + nib - 10)};
      end
      return s;
   endfunction

   function automatic string v4_text();
      string s;
      int    n, v;
      n = ($urandom_range(9) == 0) ? $urandom_range(3, 5) : 4;
      s = "";
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(19))
            0: v = 0;
            1: v = 255;
            2: v = $urandom_range(256, 999);
            default: v = $urandom_range(0, 255);
         endcase
         if (k != 0) s = {s, "."};
         if ($urandom_range(24) == 0) s = {s, "0"};
         s = {s, $sformatf("%0d", v)};
      end
      return s;
   endfunction

   function automatic string v6_text();
      string s, quad;
      bit    tail4;
      int    words, total, h;
      tail4 = ($urandom_range(3) == 0);
      words = tail4 ? 6 : 8;
      quad  = $sformatf("%0d.%0d.%0d.%0d", $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), $urandom_range(255));
      s = "";
      if ($urandom_range(2) == 0) begin
         for (int k = 0; k < words; k++) begin
            if (k != 0) s = {s, ":"};
            s = {s, hex_group()};
         end
         if (tail4) s = {s, ":", quad};
      end else begin
         total = $urandom_range(0, words - 1);
         h = $urandom_range(0, total);
         for (int k = 0; k < h; k++) begin
            if (k != 0) s = {s, ":"};
            s = {s, hex_group()};
         end
         s = {s, "::"};
         for (int k = 0; k < total - h; k++) begin
            if (k != 0) s = {s, ":"};
            s = {s, hex_group()};
         end
         if (tail4) begin
            if (total > h) s = {s, ":"};
            s = {s, quad};
         end
      end
      return s;
   endfunction

   function automatic string noise_text();
      string s, pool;
      int    n;
      pool = "0123456789abcdefABCDEF.:gx ";
      n = $urandom_range(0, 10);
      s = "";
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(1)) s = {s, $sformatf("%c", 8'($urandom_range(1, 255)))};
         else s = {s, $sformatf("%c", pool[$urandom_range(0, pool.len() - 1)])};
      end
      return s;
   endfunction

   // one random edit: insert a separator, digit or random byte, or truncate
   function automatic string mangle(string s);
      string ins;
      int    p;
      p = $urandom_range(0, s.len());
      case ($urandom_range(4))
         0: ins = ":";
         1: ins = ".";
         2: ins = $sformatf("%h", 4'($urandom_range(15)));
         3: ins = $sformatf("%c", 8'($urandom_range(1, 255)));
         default: return s.substr(0, p - 1);
      endcase
      return {s.substr(0, p - 1), ins, s.substr(p, s.len() - 1)};
   endfunction

   task automatic add_literal(string s, bit hold);
      char_item_type it;
      for (int k = 0; k <= s.len(); k++) begin
         it.ch   = (k < s.len()) ? s[k] : CHAR_END;
         it.hold = hold && (k == 0);
         char_backlog.push_back(it);
      end
      chars_queued += s.len() + 1;
   endtask

   // ---- driver ----

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         clear_literal();
      end else begin
         cyc <= cyc + 1;
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) take_char(req_char_code);
      end
   end

   always @(negedge clock) begin
      char_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 22);
         if (!req_valid || req_fire) begin
            if (char_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (char_backlog[0].hold && addr_expect.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(99) < 22) begin
               req_valid <= 1'b0;
            end else begin
               nxt = char_backlog.pop_front();
               req_valid     <= 1'b1;
               req_char_code <= nxt.ch;
               chars_sent++;
            end
         end
      end
   end

   // ---- monitor ----

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (addr_expect.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            want = addr_expect.pop_front();
            if (rsp_parse_ok !== want.parse_ok) begin
               $error("parse_ok: expected %b, got %b", want.parse_ok, rsp_parse_ok);
               errors++;
            end
            if (rsp_is_ipv6 !== want.is_ipv6) begin
               $error("is_ipv6: expected %b, got %b", want.is_ipv6, rsp_is_ipv6);
               errors++;
            end
            if (rsp_addr_upper !== want.addr_upper) begin
               $error("addr_upper: expected %h, got %h", want.addr_upper, rsp_addr_upper);
               errors++;
            end
            if (rsp_addr_lower !== want.addr_lower) begin
               $error("addr_lower: expected %h, got %h", want.addr_lower, rsp_addr_lower);
               errors++;
            end
            if (!want.parse_ok) rejected_seen++;
            else if (want.is_ipv6) v6_seen++;
            else v4_seen++;
         end
      end
   end

   // ---- stimulus and end of run ----

   initial begin
      string s;
      int    pick;
      bit    first;

      add_literal("", 1'b0);
      add_literal("0.0.0.0", 1'b0);
      add_literal("255.255.255.255", 1'b0);
      add_literal("192.168.1.10", 1'b0);
      add_literal("01.2.3.4", 1'b0);
      add_literal("256.1.2.3", 1'b0);
      add_literal("1.2.3", 1'b0);
      add_literal("1.2.3.4.", 1'b0);
      add_literal("1..2.3", 1'b0);
      add_literal("::", 1'b0);
      add_literal("::1", 1'b0);
      add_literal("1::", 1'b0);
      add_literal("ffff:FFFF:0:00:000:0000:aBcD:9", 1'b0);
      add_literal("1:2:3:4:5:6:7:8:9", 1'b0);
      add_literal("1:2:3:4:5:6:7::8", 1'b0);
      add_literal("1::2::3", 1'b0);
      add_literal(":::", 1'b0);
      add_literal(":1", 1'b0);
      add_literal("1:", 1'b0);
      add_literal("12345::", 1'b0);
      add_literal("::ffff:1.2.3.4", 1'b0);
      add_literal("1:2:3:4:5:6:7:1.2.3.4", 1'b0);
      add_literal("::1.2.3.a", 1'b0);
      add_literal({"1.2", $sformatf("%c", 8'hff), ".3.4"}, 1'b0);
      add_literal({"::", $sformatf("%c", 8'h80)}, 1'b0);

      first = 1'b1;
      while (chars_queued < 1300) begin
         pick = $urandom_range(99);
         if (pick < 45) s = v6_text();
         else if (pick < 80) s = v4_text();
         else s = noise_text();
         if (pick < 80 && $urandom_range(3) == 0) s = mangle(s);
         add_literal(s, first || ($urandom_range(29) == 0));
         first = 1'b0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_backlog.size() != 0 || req_valid) @(posedge clock);
      while (addr_expect.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d characters; checked %0d IPv4, %0d IPv6 and %0d rejected literals.",
               chars_sent, v4_seen, v6_seen, rejected_seen);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Timed out with %0d results outstanding.", addr_expect.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/iapl_pkg.sv
hw/rtl/iapl_parse.sv
hw/rtl/ip_address_literal_parser.sv
test/tb_top.sv
